/* rtl/pfp_pkg.sv */
// Shared constants, codes and the sequencer state type of the path-follow pursue-point block.
package pfp_pkg;

  // Default sizes of the point store and of one coordinate.
  localparam int unsigned MaxPointsDef  = 64;
  localparam int unsigned CoordWidthDef = 24;

  // Fixed field widths.
  localparam int unsigned LaW   = 23;
  localparam int unsigned PlW   = 7;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned CfgDw = 23;

  // Item operations.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PATH_LENGTH = 1'b0;
  localparam logic CFG_LOOK_AHEAD  = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_X,
    ST_SCAN_Y,
    ST_SCAN_C,
    ST_FETCH,
    ST_FETCH_W,
    ST_LEN_A,
    ST_LEN_B,
    ST_LEN_W,
    ST_DOT_A,
    ST_DOT_B,
    ST_DOT_W,
    ST_PX_M,
    ST_PX_W,
    ST_PY_M,
    ST_PY_W,
    ST_DA_A,
    ST_DA_B,
    ST_DA_W,
    ST_DN_A,
    ST_DN_B,
    ST_DN_W,
    ST_L2_A,
    ST_L2_B,
    ST_L2_W,
    ST_TX_M,
    ST_TX_W,
    ST_TY_M,
    ST_TY_W,
    ST_DONE
  } state_e;

endpackage

/* rtl/pfp_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module pfp_sqrt #(
  parameter int unsigned IN_W = 57
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [IN_W-1:0]           rad_i,
  output logic                      done_o,
  output logic [(IN_W+1)/2-1:0]     root_o
);

  localparam int unsigned RW = (IN_W + 1) / 2;
  localparam int unsigned EW = 2 * RW;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [EW-1:0] rad_q;
  logic [RW:0]   rem_q;
  logic [RW-1:0] root_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [RW+2:0] rem_s;
  logic [RW+2:0] trial;
  logic          fits;

  // One restoring step: bring down two bits and try root*4+1.
  assign rem_s = {rem_q, rad_q[EW-1:EW-2]};
  assign trial = (RW+3)'({root_q, 2'b01});
  assign fits  = rem_s >= trial;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CW'(RW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= EW'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[EW-3:0], 2'b00};
      rem_q  <= fits ? (RW+1)'(rem_s - trial) : (RW+1)'(rem_s);
      root_q <= {root_q[RW-2:0], fits};
      cnt_q  <= cnt_q + CW'(1);
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/pfp_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module pfp_div #(
  parameter int unsigned NUM_W = 57,
  parameter int unsigned DEN_W = 29
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   rem_s;
  logic             fits;

  // Restoring step on the magnitude; the quotient shifts in behind the dividend.
  assign rem_s = {rem_q, dvd_q[NUM_W-1]};
  assign fits  = rem_s >= (DEN_W+1)'(den_q);

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CW'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      dvd_q <= num_i[NUM_W-1] ? $unsigned(-num_i) : $unsigned(num_i);
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(rem_s - (DEN_W+1)'(den_q)) : DEN_W'(rem_s);
      dvd_q <= {dvd_q[NUM_W-2:0], fits};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

/* rtl/path_follow_pursue_point_top.sv */
// Top level of the path-follow pursue-point block: point store, sequencer and shared datapath.
//
// The block keeps a polyline in a point memory with separate write and read ports and answers
// one query at a time. A load word is written into the store when it is accepted. A query first
// scans all n valid points through the one shared multiplier, then fetches up to three points,
// and then runs the projection with that multiplier, square roots on the two-bits-per-cycle root
// unit and divisions on the one-bit-per-cycle divider, both sized from VW, the larger of
// COORD_WIDTH and 23, plus 4. Carrying the overshoot onto the following segment costs one more
// root and two more divisions; an empty path skips straight to the result, and a nearest point
// at the path end answers after the scan and the first fetch. Input stall stays high from a
// query's acceptance until its result word sits in the output register, which holds it while the
// output is stalled.
module path_follow_pursue_point_top #(
  parameter int unsigned MAX_POINTS  = pfp_pkg::MaxPointsDef,
  parameter int unsigned COORD_WIDTH = pfp_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Item input.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [pfp_pkg::IdxW-1:0]      point_index_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  // Result output.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] pursue_x_o,
  output logic signed [COORD_WIDTH-1:0] pursue_y_o,
  output logic                          path_empty_o,
  output logic                          at_path_end_o,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [pfp_pkg::CfgDw-1:0]     cfg_data_i
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned VW = ((W > pfp_pkg::LaW) ? W : pfp_pkg::LaW) + 4;
  localparam int unsigned DW = 2 * VW + 1;
  localparam int unsigned LW = VW + 1;
  localparam logic signed [VW-1:0] SatHi = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SatLo = -SatHi - VW'(1);

  pfp_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [pfp_pkg::PlW-1:0] path_length_q;
  logic [pfp_pkg::LaW-1:0] look_ahead_q;

  // Point memory, {y, x} per entry.
  logic [2*W-1:0] mem_q [MAX_POINTS];
  logic [2*W-1:0] rdata_q;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  // Query registers.
  logic signed [W-1:0]  ax_q, ay_q, cx_q, cy_q, nx_q, ny_q, n2x_q, n2y_q;
  logic [NW-1:0]        n_q, i_q;
  logic [AW-1:0]        best_q;
  logic [DW-1:0]        bestd_q;
  logic [1:0]           k_q;
  logic [LW-1:0]        len_q, l2_q, da_q;
  logic signed [VW-1:0] s_q, px_q, py_q, diff_q;
  logic signed [DW-1:0] acc_q, acc_d;
  logic                 end_q, empty_q;

  // Output register.
  logic                 out_valid_q;
  logic signed [W-1:0]  out_x_q, out_y_q;
  logic                 out_empty_q, out_end_q;

  // Shared arithmetic.
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [2*VW-1:0] prod;
  logic                   sq_start, sq_done;
  logic [LW-1:0]          sq_root;
  logic                   div_start, div_done;
  logic signed [DW-1:0]   div_num, div_quo;
  logic [LW-1:0]          div_den;

  // Derived values.
  logic                 in_acc, is_query, out_free;
  logic [NW-1:0]        n_c;
  logic signed [W-1:0]  rd_x, rd_y;
  logic signed [VW-1:0] sx, sy, tx, ty, diff_c, s0_c, div_v;
  logic [NW:0]          b1, b2;
  logic [AW-1:0]        fetch_addr;

  assign in_stall_o = (state_q != pfp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_query   = (opcode_i == pfp_pkg::OP_QUERY);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Valid point count is capped at the store depth.
  assign n_c = (32'(path_length_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(path_length_q);

  assign rd_x = $signed(rdata_q[W-1:0]);
  assign rd_y = $signed(rdata_q[2*W-1:W]);

  assign sx = VW'(nx_q) - VW'(cx_q);
  assign sy = VW'(ny_q) - VW'(cy_q);
  assign tx = VW'(n2x_q) - VW'(nx_q);
  assign ty = VW'(n2y_q) - VW'(ny_q);
  assign diff_c = $signed(VW'(da_q)) - $signed(VW'(sq_root));
  assign div_v  = VW'(div_quo);

  // Clamped projection: zero behind the segment start, the length beyond its end.
  always_comb begin
    if (acc_q < 0) begin
      s0_c = '0;
    end else if (div_quo > $signed(DW'(len_q))) begin
      s0_c = $signed(VW'(len_q));
    end else begin
      s0_c = div_v;
    end
  end

  // Fetch addresses for the nearest point, the next one and the one after it.
  assign b1 = (NW+1)'(best_q) + (NW+1)'(1);
  assign b2 = b1 + (NW+1)'(1);
  always_comb begin
    unique case (k_q)
      2'd0:    fetch_addr = best_q;
      2'd1:    fetch_addr = AW'(b1);
      default: fetch_addr = (b2 < (NW+1)'(n_q)) ? AW'(b2) : AW'(b1);
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign mem_we = in_acc && !is_query && (32'(point_index_i) < MAX_POINTS);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfp_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (n_c == '0) ? pfp_pkg::ST_DONE : pfp_pkg::ST_SCAN_X;
        end
      end
      pfp_pkg::ST_SCAN_X: state_d = pfp_pkg::ST_SCAN_Y;
      pfp_pkg::ST_SCAN_Y: state_d = pfp_pkg::ST_SCAN_C;
      pfp_pkg::ST_SCAN_C: begin
        state_d = (i_q + NW'(1) == n_q) ? pfp_pkg::ST_FETCH : pfp_pkg::ST_SCAN_X;
      end
      pfp_pkg::ST_FETCH: state_d = pfp_pkg::ST_FETCH_W;
      pfp_pkg::ST_FETCH_W: begin
        if (k_q == 2'd0 && b1 >= (NW+1)'(n_q)) begin
          state_d = pfp_pkg::ST_DONE;
        end else if (k_q == 2'd2) begin
          state_d = pfp_pkg::ST_LEN_A;
        end else begin
          state_d = pfp_pkg::ST_FETCH;
        end
      end
      pfp_pkg::ST_LEN_A: state_d = pfp_pkg::ST_LEN_B;
      pfp_pkg::ST_LEN_B: state_d = pfp_pkg::ST_LEN_W;
      pfp_pkg::ST_LEN_W: begin
        if (sq_done) begin
          state_d = (sq_root == '0) ? pfp_pkg::ST_DONE : pfp_pkg::ST_DOT_A;
        end
      end
      pfp_pkg::ST_DOT_A: state_d = pfp_pkg::ST_DOT_B;
      pfp_pkg::ST_DOT_B: state_d = pfp_pkg::ST_DOT_W;
      pfp_pkg::ST_DOT_W: if (div_done) state_d = pfp_pkg::ST_PX_M;
      pfp_pkg::ST_PX_M:  state_d = pfp_pkg::ST_PX_W;
      pfp_pkg::ST_PX_W:  if (div_done) state_d = pfp_pkg::ST_PY_M;
      pfp_pkg::ST_PY_M:  state_d = pfp_pkg::ST_PY_W;
      pfp_pkg::ST_PY_W:  if (div_done) state_d = pfp_pkg::ST_DA_A;
      pfp_pkg::ST_DA_A:  state_d = pfp_pkg::ST_DA_B;
      pfp_pkg::ST_DA_B:  state_d = pfp_pkg::ST_DA_W;
      pfp_pkg::ST_DA_W:  if (sq_done) state_d = pfp_pkg::ST_DN_A;
      pfp_pkg::ST_DN_A:  state_d = pfp_pkg::ST_DN_B;
      pfp_pkg::ST_DN_B:  state_d = pfp_pkg::ST_DN_W;
      pfp_pkg::ST_DN_W: begin
        if (sq_done) begin
          state_d = (diff_c > 0) ? pfp_pkg::ST_L2_A : pfp_pkg::ST_DONE;
        end
      end
      pfp_pkg::ST_L2_A: state_d = pfp_pkg::ST_L2_B;
      pfp_pkg::ST_L2_B: state_d = pfp_pkg::ST_L2_W;
      pfp_pkg::ST_L2_W: begin
        if (sq_done) begin
          state_d = (sq_root == '0) ? pfp_pkg::ST_DONE : pfp_pkg::ST_TX_M;
        end
      end
      pfp_pkg::ST_TX_M: state_d = pfp_pkg::ST_TX_W;
      pfp_pkg::ST_TX_W: if (div_done) state_d = pfp_pkg::ST_TY_M;
      pfp_pkg::ST_TY_M: state_d = pfp_pkg::ST_TY_W;
      pfp_pkg::ST_TY_W: if (div_done) state_d = pfp_pkg::ST_DONE;
      pfp_pkg::ST_DONE: if (out_free) state_d = pfp_pkg::ST_IDLE;
      default: state_d = pfp_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: multiplier operands, accumulator, unit starts and read address.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    acc_d     = acc_q;
    sq_start  = 1'b0;
    div_start = 1'b0;
    div_den   = len_q;
    rd_addr   = '0;
    unique case (state_q)
      pfp_pkg::ST_SCAN_X: begin
        rd_addr = i_q[AW-1:0];
        mul_a   = VW'(rd_x) - VW'(ax_q);
        mul_b   = mul_a;
        acc_d   = DW'(prod);
      end
      pfp_pkg::ST_SCAN_Y: begin
        rd_addr = i_q[AW-1:0];
        mul_a   = VW'(rd_y) - VW'(ay_q);
        mul_b   = mul_a;
        acc_d   = acc_q + DW'(prod);
      end
      pfp_pkg::ST_SCAN_C: rd_addr = AW'(i_q + NW'(1));
      pfp_pkg::ST_FETCH, pfp_pkg::ST_FETCH_W: rd_addr = fetch_addr;
      pfp_pkg::ST_LEN_A: begin
        mul_a = sx;
        mul_b = sx;
        acc_d = DW'(prod);
      end
      pfp_pkg::ST_LEN_B: begin
        mul_a    = sy;
        mul_b    = sy;
        acc_d    = acc_q + DW'(prod);
        sq_start = 1'b1;
      end
      pfp_pkg::ST_DOT_A: begin
        mul_a = VW'(ax_q) - VW'(cx_q);
        mul_b = sx;
        acc_d = DW'(prod);
      end
      pfp_pkg::ST_DOT_B: begin
        mul_a     = VW'(ay_q) - VW'(cy_q);
        mul_b     = sy;
        acc_d     = acc_q + DW'(prod);
        div_start = 1'b1;
      end
      pfp_pkg::ST_PX_M: begin
        mul_a     = sx;
        mul_b     = s_q;
        acc_d     = DW'(prod);
        div_start = 1'b1;
      end
      pfp_pkg::ST_PY_M: begin
        mul_a     = sy;
        mul_b     = s_q;
        acc_d     = DW'(prod);
        div_start = 1'b1;
      end
      pfp_pkg::ST_DA_A: begin
        mul_a = px_q - VW'(ax_q);
        mul_b = mul_a;
        acc_d = DW'(prod);
      end
      pfp_pkg::ST_DA_B: begin
        mul_a    = py_q - VW'(ay_q);
        mul_b    = mul_a;
        acc_d    = acc_q + DW'(prod);
        sq_start = 1'b1;
      end
      pfp_pkg::ST_DN_A: begin
        mul_a = VW'(nx_q) - VW'(ax_q);
        mul_b = mul_a;
        acc_d = DW'(prod);
      end
      pfp_pkg::ST_DN_B: begin
        mul_a    = VW'(ny_q) - VW'(ay_q);
        mul_b    = mul_a;
        acc_d    = acc_q + DW'(prod);
        sq_start = 1'b1;
      end
      pfp_pkg::ST_L2_A: begin
        mul_a = tx;
        mul_b = tx;
        acc_d = DW'(prod);
      end
      pfp_pkg::ST_L2_B: begin
        mul_a    = ty;
        mul_b    = ty;
        acc_d    = acc_q + DW'(prod);
        sq_start = 1'b1;
      end
      pfp_pkg::ST_TX_M: begin
        mul_a     = tx;
        mul_b     = diff_q;
        acc_d     = DW'(prod);
        div_start = 1'b1;
        div_den   = l2_q;
      end
      pfp_pkg::ST_TY_M: begin
        mul_a     = ty;
        mul_b     = diff_q;
        acc_d     = DW'(prod);
        div_start = 1'b1;
        div_den   = l2_q;
      end
      default: ;
    endcase
  end

  assign div_num = acc_d;

  pfp_sqrt #(
    .IN_W (DW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ($unsigned(acc_d)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  pfp_div #(
    .NUM_W (DW),
    .DEN_W (LW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Control state, configuration registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pfp_pkg::ST_IDLE;
      path_length_q <= '0;
      look_ahead_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pfp_pkg::CFG_PATH_LENGTH: path_length_q <= cfg_data_i[pfp_pkg::PlW-1:0];
          pfp_pkg::CFG_LOOK_AHEAD:  look_ahead_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == pfp_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Point memory with registered read.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
    if (mem_we) begin
      mem_q[AW'(point_index_i)] <= {pos_y_i, pos_x_i};
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    unique case (state_q)
      pfp_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          ax_q    <= pos_x_i;
          ay_q    <= pos_y_i;
          n_q     <= n_c;
          i_q     <= '0;
          empty_q <= (n_c == '0);
          end_q   <= 1'b0;
          px_q    <= '0;
          py_q    <= '0;
        end
      end
      pfp_pkg::ST_SCAN_C: begin
        // First point wins a tie.
        if (i_q == '0 || $unsigned(acc_q) < bestd_q) begin
          bestd_q <= $unsigned(acc_q);
          best_q  <= i_q[AW-1:0];
        end
        i_q <= i_q + NW'(1);
        k_q <= '0;
      end
      pfp_pkg::ST_FETCH_W: begin
        unique case (k_q)
          2'd0: begin
            cx_q  <= rd_x;
            cy_q  <= rd_y;
            px_q  <= VW'(rd_x);
            py_q  <= VW'(rd_y);
            end_q <= (b1 >= (NW+1)'(n_q));
          end
          2'd1: begin
            nx_q <= rd_x;
            ny_q <= rd_y;
          end
          default: begin
            n2x_q <= rd_x;
            n2y_q <= rd_y;
          end
        endcase
        k_q <= k_q + 2'd1;
      end
      pfp_pkg::ST_LEN_W: if (sq_done) len_q <= sq_root;
      pfp_pkg::ST_DOT_W: if (div_done) s_q <= s0_c + VW'(look_ahead_q);
      pfp_pkg::ST_PX_W:  if (div_done) px_q <= VW'(cx_q) + div_v;
      pfp_pkg::ST_PY_W:  if (div_done) py_q <= VW'(cy_q) + div_v;
      pfp_pkg::ST_DA_W:  if (sq_done) da_q <= sq_root;
      pfp_pkg::ST_DN_W:  if (sq_done) diff_q <= diff_c;
      pfp_pkg::ST_L2_W: begin
        // The carried excess starts from the next point.
        if (sq_done) begin
          l2_q <= sq_root;
          px_q <= VW'(nx_q);
          py_q <= VW'(ny_q);
        end
      end
      pfp_pkg::ST_TX_W: if (div_done) px_q <= VW'(nx_q) + div_v;
      pfp_pkg::ST_TY_W: if (div_done) py_q <= VW'(ny_q) + div_v;
      default: ;
    endcase
  end

  // Result word, saturated to the coordinate range.
  always_ff @(posedge clk_i) begin
    if (state_q == pfp_pkg::ST_DONE && out_free) begin
      out_x_q     <= (px_q > SatHi) ? W'(SatHi) : (px_q < SatLo) ? W'(SatLo) : px_q[W-1:0];
      out_y_q     <= (py_q > SatHi) ? W'(SatHi) : (py_q < SatLo) ? W'(SatLo) : py_q[W-1:0];
      out_empty_q <= empty_q;
      out_end_q   <= end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pursue_x_o    = out_x_q;
  assign pursue_y_o    = out_y_q;
  assign path_empty_o  = out_empty_q;
  assign at_path_end_o = out_end_q;

endmodule

/* rtl/pfp_checker.sv */
// Port-level checks for the path-follow pursue-point block, bound to its top level.
module pfp_checker #(
  parameter int unsigned COORD_WIDTH = pfp_pkg::CoordWidthDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          opcode_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [COORD_WIDTH-1:0] pursue_x_o,
  input logic signed [COORD_WIDTH-1:0] pursue_y_o,
  input logic                          path_empty_o,
  input logic                          at_path_end_o
);

  // A stalled result word stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word holds its target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pursue_x_o) && $stable(pursue_y_o))
    else $error("result word changed while stalled");

  // An empty path reports a zero target and no path end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && path_empty_o |-> pursue_x_o == '0 && pursue_y_o == '0 && !at_path_end_o)
    else $error("empty path with nonzero target");

  // A query keeps the input stalled in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == pfp_pkg::OP_QUERY |=> in_stall_o)
    else $error("query accepted without busy input");

  // A load never produces a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == pfp_pkg::OP_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("result word after a load");

endmodule

bind path_follow_pursue_point_top pfp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pfp_checker (.*);

/* tb/sv/tb_path_follow_pursue_point_top.sv */
// Testbench of the path-follow pursue-point block: directed and random path loads and queries.
module tb_path_follow_pursue_point_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPts   = pfp_pkg::MaxPointsDef;
  localparam int unsigned CW     = pfp_pkg::CoordWidthDef;
  localparam longint      CoordHi = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint      CoordLo = -CoordHi - 1;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 empty;
    logic                 at_end;
  } target_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, opcode_i;
  logic [pfp_pkg::IdxW-1:0] point_index_i;
  logic signed [CW-1:0] pos_x_i, pos_y_i;
  logic out_valid_o, out_stall_i;
  logic signed [CW-1:0] pursue_x_o, pursue_y_o;
  logic path_empty_o, at_path_end_o;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [pfp_pkg::CfgDw-1:0] cfg_data_i;

  // Shadow copy of the block's point store and registers.
  logic signed [CW-1:0] shadow_x [NPts];
  logic signed [CW-1:0] shadow_y [NPts];
  logic [pfp_pkg::PlW-1:0] shadow_plen;
  logic [pfp_pkg::LaW-1:0] shadow_la;

  target_t pending_targets[$];
  int errors, n_items, n_queries, n_results;
  int idle_cycles;
  bit quiet, hold_req, held;
  int hold_cnt;

  path_follow_pursue_point_top dut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Floor square root of an unsigned 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint dist_len(longint dx, longint dy);
    longint unsigned s;
    s = longint'(dx * dx) + longint'(dy * dy);
    return longint'(root_floor(s));
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    if (v > CoordHi) v = CoordHi;
    if (v < CoordLo) v = CoordLo;
    return v[CW-1:0];
  endfunction

  // Expected target of a query at the agent position (ax, ay).
  function automatic target_t pursue_target(longint ax, longint ay);
    target_t t;
    int n, best;
    longint unsigned d, bestd;
    longint cx, cy, nx, ny, n2x, n2y, sx, sy, len, dot, s0, s, px, py, da, dn, diff;
    longint tx, ty, l2;
    t = '0;
    n = (shadow_plen > NPts) ? NPts : shadow_plen;
    if (n == 0) begin
      t.empty = 1'b1;
      return t;
    end
    best = 0;
    bestd = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'((shadow_x[i] - ax) * (shadow_x[i] - ax)) +
          longint'((shadow_y[i] - ay) * (shadow_y[i] - ay));
      if (i == 0 || d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    cx = shadow_x[best];
    cy = shadow_y[best];
    if (best + 1 >= n) begin
      t.px = clamp_coord(cx);
      t.py = clamp_coord(cy);
      t.at_end = 1'b1;
      return t;
    end
    nx = shadow_x[best + 1];
    ny = shadow_y[best + 1];
    if (best + 2 < n) begin
      n2x = shadow_x[best + 2];
      n2y = shadow_y[best + 2];
    end else begin
      n2x = nx;
      n2y = ny;
    end
    sx = nx - cx;
    sy = ny - cy;
    len = dist_len(sx, sy);
    if (len == 0) begin
      t.px = clamp_coord(cx);
      t.py = clamp_coord(cy);
      return t;
    end
    dot = (ax - cx) * sx + (ay - cy) * sy;
    if (dot < 0) begin
      s0 = 0;
    end else begin
      s0 = dot / len;
      if (s0 > len) s0 = len;
    end
    s = s0 + longint'(shadow_la);
    px = cx + (sx * s) / len;
    py = cy + (sy * s) / len;
    da = dist_len(px - ax, py - ay);
    dn = dist_len(nx - ax, ny - ay);
    diff = da - dn;
    // Carry the overshoot onto the following segment.
    if (diff > 0) begin
      tx = n2x - nx;
      ty = n2y - ny;
      l2 = dist_len(tx, ty);
      px = nx;
      py = ny;
      if (l2 != 0) begin
        px += (tx * diff) / l2;
        py += (ty * diff) / l2;
      end
    end
    t.px = clamp_coord(px);
    t.py = clamp_coord(py);
    return t;
  endfunction

  // Send one word and update the shadow state once it is taken.
  task automatic send_word(logic op, logic [pfp_pkg::IdxW-1:0] idx, longint x, longint y);
    int gap;
    if (!quiet && $urandom_range(99) < 28) begin
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    point_index_i <= idx;
    pos_x_i       <= x[CW-1:0];
    pos_y_i       <= y[CW-1:0];
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    if (op == pfp_pkg::OP_LOAD) begin
      shadow_x[idx] = x[CW-1:0];
      shadow_y[idx] = y[CW-1:0];
    end else begin
      pending_targets = {pending_targets, pursue_target(x, y)};
      n_queries++;
    end
  endtask

  task automatic load_point(int idx, longint x, longint y);
    send_word(pfp_pkg::OP_LOAD, idx[pfp_pkg::IdxW-1:0], x, y);
  endtask

  task automatic query_at(longint x, longint y);
    send_word(pfp_pkg::OP_QUERY, '0, x, y);
  endtask

  // Write a register once every result is out and the block has settled.
  task automatic write_reg(logic idx, longint value);
    in_valid_i <= 1'b0;
    wait (pending_targets.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[pfp_pkg::CfgDw-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == pfp_pkg::CFG_PATH_LENGTH) shadow_plen = value[pfp_pkg::PlW-1:0];
    else shadow_la = value[pfp_pkg::LaW-1:0];
  endtask

  function automatic longint rand_coord();
    return longint'(signed'(CW'($urandom())));
  endfunction

  function automatic longint near(longint c, int spread);
    longint v;
    v = c + $urandom_range(2 * spread) - spread;
    if (v > CoordHi) v = CoordHi;
    if (v < CoordLo) v = CoordLo;
    return v;
  endfunction

  // Result receiver: random stalls, a long hold when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt    <= 0;
      held        <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_req && !held) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= 1500;
      held        <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 28);
    end
  end

  // Compare each result word with the oldest expected target.
  always @(posedge clk_i) begin
    target_t exp_t;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_targets.size() == 0) begin
        $error("result word with no query waiting");
        errors++;
      end else begin
        exp_t = pending_targets.pop_front();
        if (pursue_x_o !== exp_t.px) begin
          $error("pursue_x expected %0d got %0d", exp_t.px, pursue_x_o);
          errors++;
        end
        if (pursue_y_o !== exp_t.py) begin
          $error("pursue_y expected %0d got %0d", exp_t.py, pursue_y_o);
          errors++;
        end
        if (path_empty_o !== exp_t.empty) begin
          $error("path_empty expected %0b got %0b", exp_t.empty, path_empty_o);
          errors++;
        end
        if (at_path_end_o !== exp_t.at_end) begin
          $error("at_path_end expected %0b got %0b", exp_t.at_end, at_path_end_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // An empty path answers zero, and every slot gets a known point.
  task automatic test_empty_and_fill();
    query_at(CoordHi, CoordLo);
    for (int i = 0; i < NPts; i++) load_point(i, rand_coord(), rand_coord());
  endtask

  // Coordinates at the extremes, including targets that saturate.
  task automatic test_extremes();
    load_point(0, CoordLo, CoordLo);
    load_point(1, CoordHi, CoordHi);
    load_point(2, CoordHi, CoordLo);
    load_point(3, CoordLo, CoordHi);
    write_reg(pfp_pkg::CFG_PATH_LENGTH, 4);
    write_reg(pfp_pkg::CFG_LOOK_AHEAD, (1 << pfp_pkg::LaW) - 1);
    query_at(CoordLo, CoordLo);
    query_at(0, 0);
    query_at(CoordHi, CoordHi);
    query_at(CoordLo, CoordHi);
  endtask

  // Last point, second-last point, zero-length segment and overlong length.
  task automatic test_path_corners();
    load_point(0, 0, 0);
    load_point(1, 2560, 0);
    load_point(2, 2560, 2560);
    load_point(3, 2560, 2560);
    write_reg(pfp_pkg::CFG_LOOK_AHEAD, 1000);
    write_reg(pfp_pkg::CFG_PATH_LENGTH, 3);
    query_at(2600, 2700);
    query_at(2400, 100);
    query_at(100, -50);
    write_reg(pfp_pkg::CFG_PATH_LENGTH, 4);
    query_at(2500, 2600);
    write_reg(pfp_pkg::CFG_PATH_LENGTH, 1);
    query_at(-300, 40);
    write_reg(pfp_pkg::CFG_PATH_LENGTH, (1 << pfp_pkg::PlW) - 1);
    write_reg(pfp_pkg::CFG_LOOK_AHEAD, 0);
    query_at(12345, -6789);
  endtask

  // Random polylines with queries near them; mostly short paths, a few full ones.
  task automatic test_random_paths(int n_phases);
    int n, k, spread;
    longint x, y;
    for (int ph = 0; ph < n_phases; ph++) begin
      quiet = (ph >= 10 && ph < 14);
      n = ($urandom_range(9) == 0) ? NPts : $urandom_range(12, 2);
      spread = ($urandom_range(3) == 0) ? 8000000 : $urandom_range(4000, 16);
      x = rand_coord();
      y = rand_coord();
      for (int i = 0; i < n; i++) begin
        load_point(i, x, y);
        if ($urandom_range(7) != 0) begin
          x = near(x, spread);
          y = near(y, spread);
        end
      end
      case ($urandom_range(3))
        0: write_reg(pfp_pkg::CFG_LOOK_AHEAD, 0);
        1: write_reg(pfp_pkg::CFG_LOOK_AHEAD, (1 << pfp_pkg::LaW) - 1);
        default: write_reg(pfp_pkg::CFG_LOOK_AHEAD, $urandom_range(2 * spread));
      endcase
      write_reg(pfp_pkg::CFG_PATH_LENGTH, ($urandom_range(7) == 0) ? $urandom_range(127) : n);
      repeat (n > 12 ? 8 : 40) begin
        k = $urandom_range(n - 1);
        if ($urandom_range(9) == 0)
          query_at(rand_coord(), rand_coord());
        else if ($urandom_range(9) == 0)
          load_point($urandom_range(NPts - 1), near(shadow_x[k], spread),
                     near(shadow_y[k], spread));
        else
          query_at(near(shadow_x[k], spread), near(shadow_y[k], spread));
      end
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) query_at(near(shadow_x[0], 500), near(shadow_y[0], 500));
    hold_req = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    opcode_i      <= pfp_pkg::OP_LOAD;
    point_index_i <= '0;
    pos_x_i       <= '0;
    pos_y_i       <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= pfp_pkg::CFG_PATH_LENGTH;
    cfg_data_i    <= '0;
    shadow_plen   = '0;
    shadow_la     = '0;
    errors = 0;
    n_items = 0;
    n_queries = 0;
    n_results = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_fill();
    test_extremes();
    test_path_corners();
    test_backpressure();
    test_random_paths(30);

    in_valid_i <= 1'b0;
    wait (pending_targets.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("Run covered %0d words, %0d queries and %0d checked results,", n_items,
             n_queries, n_results);
    $display("over empty, short and full paths with look-ahead from zero to its maximum.");
    if (errors == 0 && pending_targets.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
